// ----- hdl/frame_time_budget_monitor_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the frame time budget monitor
// Clocked property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef FRAME_TIME_BUDGET_MONITOR_ASSERT_SVH
`define FRAME_TIME_BUDGET_MONITOR_ASSERT_SVH

// Check an implication on every rising edge, muted while reset is held.
`define FTBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication on every rising edge, muted while reset is held.
`define FTBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ftbm_pkg.sv -----
// ----------------------------------------------------------------------------
// ftbm_pkg
// Types, codes and constants of the frame time budget monitor.
// ----------------------------------------------------------------------------
package ftbm_pkg;

    localparam int NUM_CH = 12;
    localparam int IDX_W  = $clog2(NUM_CH);

    // function codes
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_END   = 2'd1;
    localparam logic [1:0] FUNC_CLR   = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    // register index (paddr[2])
    localparam logic REG_BUDGET = 1'b0;

    localparam logic [19:0] BUDGET_RST = 20'd2000;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    // floor(x/10) = (x * RECIP10) >> RECIP_SH, exact for x < 2^26
    localparam logic [23:0] RECIP10  = 24'd13421773;
    localparam int          RECIP_SH = 27;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPLY  = 6'b000010,
        S_WALK   = 6'b000100,
        S_FINISH = 6'b001000,
        S_MUL    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  channel;
        logic [23:0] amount_us;
        logic [23:0] minimum_us;
        logic        owner_thread;
    } t_item;

    typedef struct packed {
        logic [23:0] remaining_us;
        logic [31:0] spent_us;
        logic [47:0] frame_count;
        logic [47:0] work_frames;
        logic [47:0] over_frames;
        logic [47:0] grand_total_us;
        logic [31:0] worst_frame_us;
        logic [47:0] chan_sum_us;
        logic [31:0] chan_worst_us;
        logic [31:0] chan_culprits;
        logic        frame_was_over;
    } t_result;

    function automatic logic [47:0] sat_inc48(input logic [47:0] a);
        return (a == MAX48) ? MAX48 : a + 48'd1;
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        return (a == MAX32) ? MAX32 : a + 32'd1;
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? MAX48 : s[47:0];
    endfunction

endpackage

// ----- hdl/frame_time_budget_monitor.sv -----
// ----------------------------------------------------------------------------
// frame_time_budget_monitor
// Per-channel frame time budget monitor in integer microseconds.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on i_item and are accepted at a rising edge with start high
//   and busy low. Each item yields one result on o_result, valid for exactly
//   one cycle while o_done is high; the receiver cannot stall, so the result
//   is gone after that cycle.
//   Every item passes from accept to o_done through an apply state, a walk
//   over the 12 channels (one step per channel) through the shared
//   accumulate/compare unit, a step to close the frame, one for the
//   budget*0.9 multiply and one to form the result. busy is high from the
//   cycle after accept until the result shows, so a new item can be started
//   in the cycle o_done is high; no new item is taken while busy is high.
//   budget_us is written over the APB port at byte address 0 (pready is tied
//   high); write it only while the block is idle.
//   Synchronous reset (i_rst_n low) clears all statistics, returns the
//   sequencer to idle and loads the budget with 2000 us. A reset-statistics
//   item clears the same state but keeps the budget.
// ----------------------------------------------------------------------------
module frame_time_budget_monitor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                start,
    output logic                busy,
    input  ftbm_pkg::t_item     i_item,
    // result channel
    output logic                o_done,
    output ftbm_pkg::t_result   o_result,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    ftbm_pkg::t_state   r_state, n_state;
    ftbm_pkg::t_item    r_item, n_item;
    logic [ftbm_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [19:0]        r_budget;

    // per-channel stores, read through one shared address
    logic [31:0]        r_ct     [ftbm_pkg::NUM_CH];
    logic [47:0]        r_csum   [ftbm_pkg::NUM_CH];
    logic [31:0]        r_cworst [ftbm_pkg::NUM_CH];
    logic [31:0]        r_cculp  [ftbm_pkg::NUM_CH];

    logic               r_has_work, n_has_work;
    logic [47:0]        r_frames_total, n_frames_total;
    logic [47:0]        r_frames_work, n_frames_work;
    logic [47:0]        r_frames_over, n_frames_over;
    logic [47:0]        r_total, n_total;
    logic [31:0]        r_worst, n_worst;

    // walk accumulators
    logic [35:0]        r_acc, n_acc;
    logic [ftbm_pkg::IDX_W-1:0] r_lrg_idx, n_lrg_idx;
    logic [31:0]        r_lrg_val, n_lrg_val;
    logic               r_over, n_over;
    logic [31:0]        r_spent, n_spent;
    logic [47:0]        r_prod, n_prod;

    logic               r_done, n_done;
    ftbm_pkg::t_result  r_result, n_result;

    // ------------------------------------------------------------------------
    // Shared read port and per-cycle helpers
    // ------------------------------------------------------------------------
    logic [ftbm_pkg::IDX_W-1:0] rd_idx;
    logic [31:0]        ct_rd, cworst_rd, cculp_rd;
    logic [47:0]        csum_rd;
    logic               ch_ok;
    logic               work_end;
    logic               accept;
    logic               cfg_wr;

    // store write controls
    logic               ct_we, csum_we, cworst_we, cculp_we, clr_all;
    logic [31:0]        ct_wdata, cworst_wdata, cculp_wdata;
    logic [47:0]        csum_wdata;

    // arithmetic temporaries
    logic [32:0]        ct_sum;
    logic [31:0]        frame32;
    logic [23:0]        budget9;
    logic [20:0]        lim90;
    logic signed [33:0] limit, v_min, v_max;

    assign busy   = (r_state != ftbm_pkg::S_IDLE);
    assign accept = start && !busy;
    assign ch_ok  = ({28'd0, r_item.channel} < 32'(ftbm_pkg::NUM_CH));
    assign work_end = (r_item.func == ftbm_pkg::FUNC_END) && r_has_work;

    // Point the shared port at the walk index, the largest channel while
    // closing a frame, and the item's channel otherwise.
    always_comb begin
        case (r_state)
            ftbm_pkg::S_WALK:   rd_idx = r_idx;
            ftbm_pkg::S_FINISH: rd_idx = r_lrg_idx;
            default:            rd_idx = r_item.channel[ftbm_pkg::IDX_W-1:0];
        endcase
    end

    assign ct_rd     = r_ct[rd_idx];
    assign csum_rd   = r_csum[rd_idx];
    assign cworst_rd = r_cworst[rd_idx];
    assign cculp_rd  = r_cculp[rd_idx];

    assign ct_sum  = {1'b0, ct_rd} + {9'd0, r_item.amount_us};
    assign frame32 = (r_acc[35:32] != 4'd0) ? ftbm_pkg::MAX32 : r_acc[31:0];
    assign budget9 = {1'b0, r_budget, 3'b000} + {4'd0, r_budget};

    // remaining = max(minimum, min(share, floor(budget*9/10) - spent))
    assign lim90 = r_prod[ftbm_pkg::RECIP_SH +: 21];
    assign limit = $signed({13'd0, lim90}) - $signed({2'b00, r_spent});
    assign v_min = ($signed({10'd0, r_item.amount_us}) < limit) ?
                   $signed({10'd0, r_item.amount_us}) : limit;
    assign v_max = (v_min < $signed({10'd0, r_item.minimum_us})) ?
                   $signed({10'd0, r_item.minimum_us}) : v_min;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state        = r_state;
        n_item         = r_item;
        n_idx          = r_idx;
        n_has_work     = r_has_work;
        n_frames_total = r_frames_total;
        n_frames_work  = r_frames_work;
        n_frames_over  = r_frames_over;
        n_total        = r_total;
        n_worst        = r_worst;
        n_acc          = r_acc;
        n_lrg_idx      = r_lrg_idx;
        n_lrg_val      = r_lrg_val;
        n_over         = r_over;
        n_spent        = r_spent;
        n_prod         = r_prod;
        n_done         = 1'b0;
        n_result       = r_result;

        ct_we        = 1'b0;
        ct_wdata     = 32'd0;
        csum_we      = 1'b0;
        csum_wdata   = csum_rd;
        cworst_we    = 1'b0;
        cworst_wdata = cworst_rd;
        cculp_we     = 1'b0;
        cculp_wdata  = cculp_rd;
        clr_all      = 1'b0;

        case (r_state)
            ftbm_pkg::S_IDLE: begin
                if (accept) begin
                    n_item  = i_item;
                    n_state = ftbm_pkg::S_APPLY;
                end
            end

            ftbm_pkg::S_APPLY: begin
                n_idx     = '0;
                n_acc     = '0;
                n_lrg_idx = '0;
                n_lrg_val = '0;
                n_over    = 1'b0;
                case (r_item.func)
                    ftbm_pkg::FUNC_ADD: begin
                        // drop adds from foreign threads or unknown channels
                        if (r_item.owner_thread && ch_ok) begin
                            ct_we      = 1'b1;
                            ct_wdata   = ct_sum[32] ? ftbm_pkg::MAX32 : ct_sum[31:0];
                            n_has_work = 1'b1;
                        end
                    end
                    ftbm_pkg::FUNC_END: begin
                        n_frames_total = ftbm_pkg::sat_inc48(r_frames_total);
                    end
                    ftbm_pkg::FUNC_CLR: begin
                        clr_all        = 1'b1;
                        n_has_work     = 1'b0;
                        n_frames_total = '0;
                        n_frames_work  = '0;
                        n_frames_over  = '0;
                        n_total        = '0;
                        n_worst        = '0;
                    end
                    default: ;
                endcase
                n_state = ftbm_pkg::S_WALK;
            end

            ftbm_pkg::S_WALK: begin
                n_acc = r_acc + {4'd0, ct_rd};
                if (work_end) begin
                    // fold this channel into its history and clear it
                    csum_we    = 1'b1;
                    csum_wdata = ftbm_pkg::sat_add48(csum_rd, {16'd0, ct_rd});
                    if (ct_rd > cworst_rd) begin
                        cworst_we    = 1'b1;
                        cworst_wdata = ct_rd;
                    end
                    if ((r_idx == '0) || (ct_rd > r_lrg_val)) begin
                        n_lrg_idx = r_idx;
                        n_lrg_val = ct_rd;
                    end
                    ct_we    = 1'b1;
                    ct_wdata = 32'd0;
                end
                if (r_idx == ftbm_pkg::IDX_W'(ftbm_pkg::NUM_CH - 1)) begin
                    n_state = ftbm_pkg::S_FINISH;
                end else begin
                    n_idx = r_idx + ftbm_pkg::IDX_W'(1);
                end
            end

            ftbm_pkg::S_FINISH: begin
                if (work_end) begin
                    n_has_work    = 1'b0;
                    n_spent       = 32'd0;
                    n_frames_work = ftbm_pkg::sat_inc48(r_frames_work);
                    n_total       = ftbm_pkg::sat_add48(r_total, {16'd0, frame32});
                    if (frame32 > r_worst) begin
                        n_worst = frame32;
                    end
                    if (frame32 > {12'd0, r_budget}) begin
                        n_frames_over = ftbm_pkg::sat_inc48(r_frames_over);
                        cculp_we      = 1'b1;
                        cculp_wdata   = ftbm_pkg::sat_inc32(cculp_rd);
                        n_over        = 1'b1;
                    end
                end else begin
                    n_spent = frame32;
                end
                n_state = ftbm_pkg::S_MUL;
            end

            ftbm_pkg::S_MUL: begin
                n_prod  = {24'd0, budget9} * {24'd0, ftbm_pkg::RECIP10};
                n_state = ftbm_pkg::S_OUT;
            end

            ftbm_pkg::S_OUT: begin
                n_done = 1'b1;
                n_result.remaining_us   = (r_item.func == ftbm_pkg::FUNC_QUERY) ?
                                          v_max[23:0] : 24'd0;
                n_result.spent_us       = r_spent;
                n_result.frame_count    = r_frames_total;
                n_result.work_frames    = r_frames_work;
                n_result.over_frames    = r_frames_over;
                n_result.grand_total_us = r_total;
                n_result.worst_frame_us = r_worst;
                n_result.chan_sum_us    = ch_ok ? csum_rd   : 48'd0;
                n_result.chan_worst_us  = ch_ok ? cworst_rd : 32'd0;
                n_result.chan_culprits  = ch_ok ? cculp_rd  : 32'd0;
                n_result.frame_was_over = r_over;
                n_state = ftbm_pkg::S_IDLE;
            end

            default: begin
                n_state = ftbm_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ftbm_pkg::S_IDLE;
            r_done         <= 1'b0;
            r_has_work     <= 1'b0;
            r_frames_total <= '0;
            r_frames_work  <= '0;
            r_frames_over  <= '0;
            r_total        <= '0;
            r_worst        <= '0;
            r_spent        <= '0;
            r_over         <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_done         <= n_done;
            r_has_work     <= n_has_work;
            r_frames_total <= n_frames_total;
            r_frames_work  <= n_frames_work;
            r_frames_over  <= n_frames_over;
            r_total        <= n_total;
            r_worst        <= n_worst;
            r_spent        <= n_spent;
            r_over         <= n_over;
        end
    end

    // payload and walk scratch: no reset needed
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_idx     <= n_idx;
        r_acc     <= n_acc;
        r_lrg_idx <= n_lrg_idx;
        r_lrg_val <= n_lrg_val;
        r_prod    <= n_prod;
        r_result  <= n_result;
    end

    // per-channel stores: cleared by reset and by a reset-statistics item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            for (int i = 0; i < ftbm_pkg::NUM_CH; i++) begin
                r_ct[i]     <= '0;
                r_csum[i]   <= '0;
                r_cworst[i] <= '0;
                r_cculp[i]  <= '0;
            end
        end else begin
            if (ct_we)     r_ct[rd_idx]     <= ct_wdata;
            if (csum_we)   r_csum[rd_idx]   <= csum_wdata;
            if (cworst_we) r_cworst[rd_idx] <= cworst_wdata;
            if (cculp_we)  r_cculp[rd_idx]  <= cculp_wdata;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ftbm_pkg::REG_BUDGET);
    assign prdata = (paddr[2] == ftbm_pkg::REG_BUDGET) ? {12'd0, r_budget} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= ftbm_pkg::BUDGET_RST;
        end else if (cfg_wr) begin
            r_budget <= pwdata[19:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- hdl/ftbm_checker.sv -----
// ----------------------------------------------------------------------------
// ftbm_checker
// Port-level checks of the frame time budget monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_time_budget_monitor_assert.svh"

module ftbm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input ftbm_pkg::t_result   o_result
);

    // an accepted item keeps the block busy
    `FTBM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept without busy")

    // the result strobe lasts one cycle
    `FTBM_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result strobe held")

    // busy drops exactly when the result shows
    `FTBM_ASSERT_IMP(a_done_on_fall, i_clk, i_rst_n, $fell(busy), o_done, "busy fell without result")

    // an over-budget frame is counted as both working and over
    `FTBM_ASSERT_IMP(a_over_counted, i_clk, i_rst_n, o_done && o_result.frame_was_over,
        (o_result.over_frames != 48'd0) && (o_result.work_frames != 48'd0), "over frame not counted")

endmodule

bind frame_time_budget_monitor ftbm_checker u_ftbm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
